>>> rtl/cmh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cmh_pkg;

    localparam int NODE_CAPACITY = 1024;
    localparam int MAX_BUCKETS   = 512;
    localparam int KEY_BYTES     = 8;

    localparam int NODE_W    = $clog2(NODE_CAPACITY + 1);
    localparam int ADDR_W    = $clog2(NODE_CAPACITY);
    localparam int BKT_AW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int BCNT_W    = $clog2(MAX_BUCKETS + 1);
    localparam int KCNT_W    = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int ENTRIES_W = 11;

    localparam logic [NODE_W-1:0] NIL       = NODE_W'(NODE_CAPACITY);
    localparam logic [31:0]       HASH_SEED = 32'd5381;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_GET   = 2'd1,
        ACT_TAKE  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [4:0] {
        S_IDLE, S_HASH, S_DISPATCH, S_ALLOC_RD, S_ALLOC_WAIT, S_STORE,
        S_RH_HEAD, S_RH_START, S_RH_CHK, S_RH_WAIT, S_RH_LO_FIN, S_RH_HI_FIN,
        S_LINK_RD, S_LINK_START, S_TAIL_RD, S_TAIL_WAIT,
        S_FIND_START, S_FIND_CHK, S_FIND_WAIT, S_TAKE_FIX, S_TAKE_FREE, S_DONE
    } state_t;

endpackage
`default_nettype wire

>>> rtl/cmh_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module cmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/cmh_hash.sv
`timescale 1ns / 1ps
`default_nettype none
module cmh_hash (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] key,
    output logic             busy,
    output logic [31:0]      hash
);
    import cmh_pkg::*;

    logic [31:0]       h_reg, h_next;
    logic [63:0]       shift_reg, shift_next;
    logic [KCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;

    always_comb begin
        h_next     = h_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (start) begin
            h_next     = HASH_SEED;
            shift_next = key;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            // one byte per cycle: h = h*33 ^ byte
            h_next     = ((h_reg << 5) + h_reg) ^ {24'd0, shift_reg[7:0]};
            shift_next = shift_reg >> 8;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == KCNT_W'(KEY_BYTES - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        h_reg     <= h_next;
        shift_reg <= shift_next;
        cnt_reg   <= cnt_next;
    end

    assign busy = busy_reg;
    assign hash = h_reg;
endmodule
`default_nettype wire

>>> rtl/chained_hash_map_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Hash map with chained buckets over a pool of NODE_CAPACITY nodes held in
// single-port-write RAMs. One request is handled at a time: s_ready is high
// only while the sequencer is idle. A request first passes through the
// byte-serial hash unit, then a get or take walks its bucket chain node by
// node through the node RAM read port. Clear and a pool-full add skip the
// chain walk; take unlinks the node it finds and pushes it onto the recycle
// list, and add reuses a freed node when one is on that list, walking the
// chain to its tail when appending. An add that grows the table rehashes
// every old bucket first. No clearing pass is needed after reset.
module chained_hash_map_engine (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_action,
    input  wire logic                          s_append,
    input  wire logic [63:0]                   s_key,
    input  wire logic [63:0]                   s_value_in,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [1:0]                         m_status,
    output logic [63:0]                        m_value_out,
    output logic [cmh_pkg::ENTRIES_W-1:0]      m_entries
);
    import cmh_pkg::*;

    state_t state_reg, state_next;

    action_t           act_reg, act_next;
    logic              app_reg, app_next;
    logic [63:0]       key_reg, key_next;
    logic [63:0]       val_reg, val_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [NODE_W-1:0] prev_reg, prev_next;
    logic [NODE_W-1:0] nxt_reg, nxt_next;
    logic [NODE_W-1:0] fresh_reg, fresh_next;
    logic [NODE_W-1:0] rec_reg, rec_next;
    logic [NODE_W-1:0] count_reg, count_next;
    logic [BCNT_W-1:0] bcnt_reg, bcnt_next;
    logic [BCNT_W-1:0] b_reg, b_next;
    logic [NODE_W-1:0] lo_reg, lo_next, lo_t_reg, lo_t_next;
    logic [NODE_W-1:0] hi_reg, hi_next, hi_t_reg, hi_t_next;
    logic [1:0]        status_reg, status_next;
    logic [63:0]       vout_reg, vout_next;

    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           m_status_reg, m_status_next;
    logic [63:0]          m_vout_reg, m_vout_next;
    logic [ENTRIES_W-1:0] m_ent_reg, m_ent_next;

    logic        hash_start, hash_busy;
    logic [31:0] hash;

    logic [ADDR_W-1:0] node_raddr, node_waddr;
    logic              node_we;
    logic [63:0]       key_rdata, val_rdata;
    logic [31:0]       hash_rdata;

    logic              link_we;
    logic [ADDR_W-1:0] link_waddr;
    logic [NODE_W-1:0] link_wdata, link_rdata;

    logic              bh_we;
    logic [BKT_AW-1:0] bh_waddr, bh_raddr, bi;
    logic [NODE_W-1:0] bh_wdata, bh_rdata;

    logic [BCNT_W-1:0] b_hi;

    cmh_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (s_key),
        .busy    (hash_busy),
        .hash    (hash)
    );

    cmh_ram #(.WIDTH(64), .DEPTH(NODE_CAPACITY)) u_key_ram (
        .aclk(aclk), .we(node_we), .waddr(node_waddr), .wdata(key_reg),
        .raddr(node_raddr), .rdata(key_rdata)
    );
    cmh_ram #(.WIDTH(32), .DEPTH(NODE_CAPACITY)) u_hash_ram (
        .aclk(aclk), .we(node_we), .waddr(node_waddr), .wdata(hash),
        .raddr(node_raddr), .rdata(hash_rdata)
    );
    cmh_ram #(.WIDTH(64), .DEPTH(NODE_CAPACITY)) u_val_ram (
        .aclk(aclk), .we(node_we), .waddr(node_waddr), .wdata(val_reg),
        .raddr(node_raddr), .rdata(val_rdata)
    );
    cmh_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAPACITY)) u_link_ram (
        .aclk(aclk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(node_raddr), .rdata(link_rdata)
    );
    cmh_ram #(.WIDTH(NODE_W), .DEPTH(MAX_BUCKETS)) u_bh_ram (
        .aclk(aclk), .we(bh_we), .waddr(bh_waddr), .wdata(bh_wdata),
        .raddr(bh_raddr), .rdata(bh_rdata)
    );

    assign bi         = BKT_AW'(hash[BCNT_W-1:0] & (bcnt_reg - 1'b1));
    assign node_raddr = cur_reg[ADDR_W-1:0];
    assign node_waddr = node_reg[ADDR_W-1:0];
    assign b_hi       = b_reg + bcnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fresh_reg   <= '0;
            rec_reg     <= NIL;
            count_reg   <= '0;
            bcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fresh_reg   <= fresh_next;
            rec_reg     <= rec_next;
            count_reg   <= count_next;
            bcnt_reg    <= bcnt_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg      <= act_next;
        app_reg      <= app_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        node_reg     <= node_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        nxt_reg      <= nxt_next;
        b_reg        <= b_next;
        lo_reg       <= lo_next;
        lo_t_reg     <= lo_t_next;
        hi_reg       <= hi_next;
        hi_t_reg     <= hi_t_next;
        status_reg   <= status_next;
        vout_reg     <= vout_next;
        m_status_reg <= m_status_next;
        m_vout_reg   <= m_vout_next;
        m_ent_reg    <= m_ent_next;
    end

    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        app_next      = app_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        node_next     = node_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        nxt_next      = nxt_reg;
        fresh_next    = fresh_reg;
        rec_next      = rec_reg;
        count_next    = count_reg;
        bcnt_next     = bcnt_reg;
        b_next        = b_reg;
        lo_next       = lo_reg;
        lo_t_next     = lo_t_reg;
        hi_next       = hi_reg;
        hi_t_next     = hi_t_reg;
        status_next   = status_reg;
        vout_next     = vout_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_vout_next   = m_vout_reg;
        m_ent_next    = m_ent_reg;
        hash_start    = 1'b0;
        node_we       = 1'b0;
        link_we       = 1'b0;
        link_waddr    = node_reg[ADDR_W-1:0];
        link_wdata    = NIL;
        bh_we         = 1'b0;
        bh_waddr      = bi;
        bh_wdata      = node_reg;
        bh_raddr      = bi;
        s_ready       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    act_next    = action_t'(s_action);
                    app_next    = s_append;
                    key_next    = s_key;
                    val_next    = s_value_in;
                    status_next = ST_OK;
                    vout_next   = '0;
                    state_next  = S_HASH;
                end
            end
            S_HASH: begin
                if (!hash_busy) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (act_reg)
                    ACT_CLEAR: begin
                        fresh_next = '0;
                        rec_next   = NIL;
                        count_next = '0;
                        bcnt_next  = '0;
                        state_next = S_DONE;
                    end
                    ACT_ADD: begin
                        if (count_reg == NIL) begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end else if (rec_reg != NIL) begin
                            node_next  = rec_reg;
                            cur_next   = rec_reg;
                            state_next = S_ALLOC_RD;
                        end else begin
                            node_next  = fresh_reg;
                            fresh_next = fresh_reg + 1'b1;
                            state_next = S_STORE;
                        end
                    end
                    default: begin
                        status_next = ST_MISS;
                        // bucket head read at bi issues this cycle
                        state_next  = (bcnt_reg == '0) ? S_DONE : S_FIND_START;
                    end
                endcase
            end
            S_ALLOC_RD: begin
                state_next = S_ALLOC_WAIT;
            end
            S_ALLOC_WAIT: begin
                rec_next   = link_rdata;
                state_next = S_STORE;
            end
            S_STORE: begin
                node_we = 1'b1;
                link_we = 1'b1;
                if (int'(count_reg >> 1) >= int'(bcnt_reg)) begin
                    if (bcnt_reg == '0) begin
                        bh_we      = 1'b1;
                        bh_waddr   = '0;
                        bh_wdata   = NIL;
                        bcnt_next  = BCNT_W'(1);
                        state_next = S_LINK_RD;
                    end else if (int'(bcnt_reg) <= MAX_BUCKETS / 2) begin
                        b_next     = '0;
                        state_next = S_RH_HEAD;
                    end else begin
                        state_next = S_LINK_RD;
                    end
                end else begin
                    state_next = S_LINK_RD;
                end
            end
            S_RH_HEAD: begin
                bh_raddr   = BKT_AW'(b_reg);
                state_next = S_RH_START;
            end
            S_RH_START: begin
                cur_next   = bh_rdata;
                lo_next    = NIL;
                lo_t_next  = NIL;
                hi_next    = NIL;
                hi_t_next  = NIL;
                state_next = S_RH_CHK;
            end
            S_RH_CHK: begin
                state_next = (cur_reg == NIL) ? S_RH_LO_FIN : S_RH_WAIT;
            end
            S_RH_WAIT: begin
                // split chain, keep order: append cur to low or high list
                if ((hash_rdata[BCNT_W-1:0] & bcnt_reg) != '0) begin
                    if (hi_t_reg != NIL) begin
                        link_we    = 1'b1;
                        link_waddr = hi_t_reg[ADDR_W-1:0];
                        link_wdata = cur_reg;
                    end else begin
                        hi_next = cur_reg;
                    end
                    hi_t_next = cur_reg;
                end else begin
                    if (lo_t_reg != NIL) begin
                        link_we    = 1'b1;
                        link_waddr = lo_t_reg[ADDR_W-1:0];
                        link_wdata = cur_reg;
                    end else begin
                        lo_next = cur_reg;
                    end
                    lo_t_next = cur_reg;
                end
                cur_next   = link_rdata;
                state_next = S_RH_CHK;
            end
            S_RH_LO_FIN: begin
                link_we    = (lo_t_reg != NIL);
                link_waddr = lo_t_reg[ADDR_W-1:0];
                bh_we      = 1'b1;
                bh_waddr   = BKT_AW'(b_reg);
                bh_wdata   = lo_reg;
                state_next = S_RH_HI_FIN;
            end
            S_RH_HI_FIN: begin
                link_we    = (hi_t_reg != NIL);
                link_waddr = hi_t_reg[ADDR_W-1:0];
                bh_we      = 1'b1;
                bh_waddr   = BKT_AW'(b_hi);
                bh_wdata   = hi_reg;
                if (b_reg + 1'b1 == bcnt_reg) begin
                    bcnt_next  = bcnt_reg << 1;
                    state_next = S_LINK_RD;
                end else begin
                    b_next     = b_reg + 1'b1;
                    state_next = S_RH_HEAD;
                end
            end
            S_LINK_RD: begin
                state_next = S_LINK_START;
            end
            S_LINK_START: begin
                if (app_reg && bh_rdata != NIL) begin
                    cur_next   = bh_rdata;
                    state_next = S_TAIL_RD;
                end else begin
                    link_we    = 1'b1;
                    link_wdata = bh_rdata;
                    bh_we      = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end
            end
            S_TAIL_RD: begin
                state_next = S_TAIL_WAIT;
            end
            S_TAIL_WAIT: begin
                if (link_rdata == NIL) begin
                    link_we    = 1'b1;
                    link_waddr = cur_reg[ADDR_W-1:0];
                    link_wdata = node_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end else begin
                    cur_next   = link_rdata;
                    state_next = S_TAIL_RD;
                end
            end
            S_FIND_START: begin
                cur_next   = bh_rdata;
                prev_next  = NIL;
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK: begin
                state_next = (cur_reg == NIL) ? S_DONE : S_FIND_WAIT;
            end
            S_FIND_WAIT: begin
                if (hash_rdata == hash && key_rdata == key_reg) begin
                    status_next = ST_OK;
                    vout_next   = val_rdata;
                    nxt_next    = link_rdata;
                    state_next  = (act_reg == ACT_TAKE) ? S_TAKE_FIX : S_DONE;
                end else begin
                    prev_next  = cur_reg;
                    cur_next   = link_rdata;
                    state_next = S_FIND_CHK;
                end
            end
            S_TAKE_FIX: begin
                if (prev_reg != NIL) begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg[ADDR_W-1:0];
                    link_wdata = nxt_reg;
                end else begin
                    bh_we    = 1'b1;
                    bh_wdata = nxt_reg;
                end
                state_next = S_TAKE_FREE;
            end
            S_TAKE_FREE: begin
                // push freed node onto the recycle list
                link_we    = 1'b1;
                link_waddr = cur_reg[ADDR_W-1:0];
                link_wdata = rec_reg;
                rec_next   = cur_reg;
                count_next = count_reg - 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_vout_next   = vout_reg;
                    m_ent_next    = ENTRIES_W'(count_reg);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg == S_IDLE && s_valid) begin
            hash_start = 1'b1;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_value_out = m_vout_reg;
    assign m_entries   = m_ent_reg;
endmodule
`default_nettype wire

>>> rtl/cmh_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module cmh_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [1:0]                    m_status,
    input wire logic [63:0]                   m_value_out,
    input wire logic [cmh_pkg::ENTRIES_W-1:0] m_entries
);
    import cmh_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_value_out) && $stable(m_entries))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after an accepted request");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> m_entries == ENTRIES_W'(NODE_CAPACITY))
        else $error("pool full reported below capacity");

    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_value_out == '0)
        else $error("value on a failed request");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind chained_hash_map_engine cmh_checker u_cmh_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_value_out (m_value_out),
    .m_entries   (m_entries)
);
`default_nettype wire
